/* design/spa_pkg.sv */
// ----------------------------------------------------------------------------
// spa_pkg: shared types and constants of the scattering phase accumulator
// Holds the sizing constants, the sequencer states and the CORDIC angle table.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int MAX_TERMS      = 256;
  localparam int ROTATION_STEPS = 16;
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int ROT_STEPS_EFF  = (ROTATION_STEPS < ANGLE_TABLE_LEN) ?
                                  ROTATION_STEPS : ANGLE_TABLE_LEN;
  localparam int STEP_W         = $clog2(ANGLE_TABLE_LEN);
  localparam int COUNT_W        = $clog2(MAX_TERMS + 1);
  localparam int ROT_W          = 24;
  localparam int SUM_W          = 32;
  localparam int TOTAL_W        = 9;
  localparam int Q15_W          = 16;
  localparam int DOT_W          = 48;
  localparam int SEQ_W          = 3;

  localparam logic signed [ROT_W-1:0] CORDIC_X0 = 24'sd2547003;
  localparam logic signed [Q15_W-1:0] Q15_MAX   = 16'sd32767;

  localparam logic [SEQ_W-1:0] SEQ_MUL_X  = 3'd0;
  localparam logic [SEQ_W-1:0] SEQ_MUL_Y  = 3'd1;
  localparam logic [SEQ_W-1:0] SEQ_MUL_Z  = 3'd2;
  localparam logic [SEQ_W-1:0] SEQ_DOT    = 3'd3;
  localparam logic [SEQ_W-1:0] SEQ_MUL_LO = 3'd4;
  localparam logic [SEQ_W-1:0] SEQ_MUL_HI = 3'd5;
  localparam logic [SEQ_W-1:0] SEQ_PHASE  = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ROT,
    S_ADD
  } spa_state_t;

  function automatic logic signed [ROT_W-1:0] angle_turns(input logic [STEP_W-1:0] i);
    logic signed [ROT_W-1:0] a;
    case (i)
      5'd0:    a = 24'sd2097152;
      5'd1:    a = 24'sd1238021;
      5'd2:    a = 24'sd654136;
      5'd3:    a = 24'sd332050;
      5'd4:    a = 24'sd166669;
      5'd5:    a = 24'sd83416;
      5'd6:    a = 24'sd41718;
      5'd7:    a = 24'sd20860;
      5'd8:    a = 24'sd10430;
      5'd9:    a = 24'sd5215;
      5'd10:   a = 24'sd2608;
      5'd11:   a = 24'sd1304;
      5'd12:   a = 24'sd652;
      5'd13:   a = 24'sd326;
      5'd14:   a = 24'sd163;
      5'd15:   a = 24'sd81;
      5'd16:   a = 24'sd41;
      5'd17:   a = 24'sd20;
      5'd18:   a = 24'sd10;
      5'd19:   a = 24'sd5;
      5'd20:   a = 24'sd3;
      5'd21:   a = 24'sd1;
      5'd22:   a = 24'sd1;
      default: a = 24'sd0;
    endcase
    return a;
  endfunction

endpackage

/* design/spa_term_if.sv */
// ----------------------------------------------------------------------------
// spa_term_if: input request channel
// Carries one displacement and wave-vector triple with its run marker.
// ----------------------------------------------------------------------------
interface spa_term_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] disp_x;
  logic signed [31:0] disp_y;
  logic signed [31:0] disp_z;
  logic signed [10:0] wave_x;
  logic signed [10:0] wave_y;
  logic signed [10:0] wave_z;
  logic               last_term;

  modport source (output valid, disp_x, disp_y, disp_z, wave_x, wave_y, wave_z,
                  last_term, input ready);
  modport sink (input valid, disp_x, disp_y, disp_z, wave_x, wave_y, wave_z,
                last_term, output ready);
endinterface

/* design/spa_result_if.sv */
// ----------------------------------------------------------------------------
// spa_result_if: result request channel
// Carries the cosine and sine sums and the term count of one run.
// ----------------------------------------------------------------------------
interface spa_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cos_total;
  logic signed [31:0] sin_total;
  logic        [8:0]  term_total;

  modport source (output valid, cos_total, sin_total, term_total, input ready);
  modport sink (input valid, cos_total, sin_total, term_total, output ready);
endinterface

/* design/scattering_phase_accumulator.sv */
// ----------------------------------------------------------------------------
// scattering_phase_accumulator: self intermediate scattering sum
// Phase from displacement and wave vector, CORDIC cosine and sine, run sums.
// ----------------------------------------------------------------------------
// Usage:
//   term   - input requests: displacement (Q16.16), wave-vector triple and
//            last_term. Accepted when valid and ready are high; ready is high
//            only while the block is idle.
//   result - one request per run, on the term marked last_term: saturated
//            cosine and sine sums (Q1.15 units) and the term count.
//   wr_en / wr_data - write inv_box_length (Q0.32) while idle; reset 2^24.
// Flow: one shared 33x25 multiplier runs the three dot-product terms and the
//   two scaling partial products, the rotator then runs ROTATION_STEPS steps
//   (16), and the add cycle adds into the sums; a new term is accepted only
//   once the block is back in idle. Terms beyond MAX_TERMS skip to the add
//   cycle and are not counted.
// Reset clears the sums, the count, the result valid flag and the sequencer.
// A stalled receiver holds the result in its output register; the next run
//   proceeds and waits in the add cycle of its last term until the register
//   is free.
// ----------------------------------------------------------------------------
module scattering_phase_accumulator
  import spa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  spa_term_if.sink    term,
  spa_result_if.source result,
  input  logic        wr_en,
  input  logic [31:0] wr_data
);

  spa_state_t state, state_next;

  logic [31:0]              inv_box_length;
  logic signed [31:0]       disp_x, disp_y, disp_z;
  logic signed [10:0]       wave_x, wave_y, wave_z;
  logic                     last;
  logic                     active;
  logic [SEQ_W-1:0]         seq;
  logic [STEP_W-1:0]        step;
  logic signed [DOT_W-1:0]  dot;
  logic [23:0]              phase_lo;
  logic signed [57:0]       prod;
  logic signed [ROT_W-1:0]  rx, ry, rz;
  logic [1:0]               quad;
  logic signed [SUM_W-1:0]  cos_sum, sin_sum;
  logic [COUNT_W-1:0]       term_count;

  logic                     accept;
  logic                     slot_free;
  logic                     mul_done;
  logic                     rot_done;
  logic                     emit;
  logic signed [32:0]       mul_a;
  logic signed [24:0]       mul_b;
  logic [23:0]              phase;
  logic signed [Q15_W-1:0]  cq, sq, c_term, s_term;
  logic signed [SUM_W-1:0]  cos_new, sin_new;

  function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [ROT_W-1:0] v);
    logic signed [ROT_W:0]   r;
    logic signed [Q15_W-1:0] q;
    r = ($signed({v[ROT_W-1], v}) + 25'sd64) >>> 7;
    if (r > 25'(Q15_MAX)) begin
      q = Q15_MAX;
    end else if (r < -25'(Q15_MAX)) begin
      q = -Q15_MAX;
    end else begin
      q = r[Q15_W-1:0];
    end
    return q;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [Q15_W-1:0] b);
    logic signed [SUM_W:0]   s;
    logic signed [SUM_W-1:0] r;
    s = {a[SUM_W-1], a} + {{(SUM_W-Q15_W+1){b[Q15_W-1]}}, b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = s[SUM_W-1:0];
    end
    return r;
  endfunction

  assign slot_free = !result.valid || result.ready;
  assign mul_done  = (seq == SEQ_PHASE);
  assign rot_done  = (step == STEP_W'(ROT_STEPS_EFF - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (term.valid) begin
          state_next = (term_count < COUNT_W'(MAX_TERMS)) ? S_MUL : S_ADD;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          state_next = S_ROT;
        end
      end
      S_ROT: begin
        if (rot_done) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        if (!last || slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    term.ready = (state == S_IDLE);
    accept     = term.valid && term.ready;
    emit       = (state == S_ADD) && last && slot_free;
    mul_a      = '0;
    mul_b      = '0;
    case (seq)
      SEQ_MUL_X: begin
        mul_a = {disp_x[31], disp_x};
        mul_b = {{14{wave_x[10]}}, wave_x};
      end
      SEQ_MUL_Y: begin
        mul_a = {disp_y[31], disp_y};
        mul_b = {{14{wave_y[10]}}, wave_y};
      end
      SEQ_MUL_Z: begin
        mul_a = {disp_z[31], disp_z};
        mul_b = {{14{wave_z[10]}}, wave_z};
      end
      SEQ_MUL_LO: begin
        mul_a = {1'b0, inv_box_length};
        mul_b = {1'b0, dot[23:0]};
      end
      SEQ_MUL_HI: begin
        mul_a = {1'b0, inv_box_length};
        mul_b = {1'b0, dot[47:24]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign phase  = phase_lo + prod[23:0];
  assign cq     = to_q15(rx);
  assign sq     = to_q15(ry);

  always_comb begin
    case (quad)
      2'd0:    begin c_term = cq;  s_term = sq;  end
      2'd1:    begin c_term = -sq; s_term = cq;  end
      2'd2:    begin c_term = -cq; s_term = -sq; end
      default: begin c_term = sq;  s_term = -cq; end
    endcase
  end

  assign cos_new = active ? sat_add(cos_sum, c_term) : cos_sum;
  assign sin_new = active ? sat_add(sin_sum, s_term) : sin_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_box_length <= 32'd16777216;
    end else if (wr_en) begin
      inv_box_length <= wr_data;
    end
  end

  // hold the request
  always_ff @(posedge clk) begin
    if (accept) begin
      disp_x <= term.disp_x;
      disp_y <= term.disp_y;
      disp_z <= term.disp_z;
      wave_x <= term.wave_x;
      wave_y <= term.wave_y;
      wave_z <= term.wave_z;
      last   <= term.last_term;
    end
  end

  // shared multiplier and phase sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      seq    <= SEQ_MUL_X;
      active <= 1'b0;
    end else if (accept) begin
      seq    <= SEQ_MUL_X;
      active <= (term_count < COUNT_W'(MAX_TERMS));
    end else if (state == S_MUL && !mul_done) begin
      seq <= seq + SEQ_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (accept) begin
      dot <= '0;
    end else if (state == S_MUL) begin
      if (seq == SEQ_MUL_Y || seq == SEQ_MUL_Z || seq == SEQ_DOT) begin
        dot <= dot + prod[DOT_W-1:0];
      end
      if (seq == SEQ_MUL_HI) begin
        phase_lo <= prod[47:24];
      end
    end
  end

  // rotator
  always_ff @(posedge clk) begin
    if (state == S_MUL && mul_done) begin
      rx   <= CORDIC_X0;
      ry   <= '0;
      rz   <= {2'b00, phase[21:0]};
      quad <= phase[23:22];
      step <= '0;
    end else if (state == S_ROT) begin
      if (!rz[ROT_W-1]) begin
        rx <= rx - (ry >>> step);
        ry <= ry + (rx >>> step);
        rz <= rz - angle_turns(step);
      end else begin
        rx <= rx + (ry >>> step);
        ry <= ry - (rx >>> step);
        rz <= rz + angle_turns(step);
      end
      if (!rot_done) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  // sums and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_sum    <= '0;
      sin_sum    <= '0;
      term_count <= '0;
    end else if (emit) begin
      cos_sum    <= '0;
      sin_sum    <= '0;
      term_count <= '0;
    end else if (state == S_ADD && !last) begin
      cos_sum    <= cos_new;
      sin_sum    <= sin_new;
      term_count <= term_count + COUNT_W'(active);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.cos_total  <= cos_new;
      result.sin_total  <= sin_new;
      result.term_total <= TOTAL_W'(term_count + COUNT_W'(active));
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    term_count <= COUNT_W'(MAX_TERMS))
    else $error("term count beyond limit");

  a_accept_path: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_MUL || state == S_ADD))
    else $error("accepted request did not start work");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !$past(result.valid)) |-> $past(emit))
    else $error("result raised without an emitting add cycle");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    emit |=> (term_count == '0 && cos_sum == '0 && sin_sum == '0))
    else $error("sums not cleared after result");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROT) |-> (step < STEP_W'(ROT_STEPS_EFF)))
    else $error("rotator step out of range");
`endif

endmodule
